// ===== rtl/scoc_pkg.sv =====
package scoc_pkg;

    localparam logic [11:0] INITIAL_SETPOINT = 12'd25;
    localparam logic [7:0]  DUMMY_BYTE_RST   = 8'd0;
    localparam logic [7:0]  TICKS_RST        = 8'd10;

    localparam logic [2:0] DEVICE_BIT = 3'd4;
    localparam logic [2:0] AC_BIT     = 3'd5;

    localparam logic OP_SPI  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic CFG_DUMMY_BYTE = 1'b0;
    localparam logic CFG_TICKS      = 1'b1;

    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_W = 8'h57;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_2 = 8'h32;
    localparam logic [7:0] CH_4 = 8'h34;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ROOM,
        PH_SIGNAL,
        PH_ORDER,
        PH_ASUB,
        PH_TENS,
        PH_UNITS,
        PH_STATUS
    } t_phase;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic [9:0] adc_sample;
    } t_in_req;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic [5:0]  output_bits;
        logic [11:0] setpoint_value;
        logic        cooling_enabled;
    } t_out_req;

    typedef struct packed {
        logic       we;
        logic       idx;
        logic [7:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        t_phase      phase;
        logic [5:0]  latch;
        logic        tick_enable;
        logic [11:0] setpoint;
    } t_core_stat;

endpackage

// ===== rtl/scoc_core.sv =====
module scoc_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  scoc_pkg::t_in_req     i_req,
    input  scoc_pkg::t_cfg_wr     i_cfg,
    output scoc_pkg::t_out_req    o_res,
    output scoc_pkg::t_core_stat  o_stat
);

    logic [7:0]       r_dummy;
    logic [7:0]       r_tps;
    scoc_pkg::t_phase r_phase;
    logic [2:0]       r_target;
    logic             r_pending;
    logic [5:0]       r_latch;
    logic             r_en;
    logic [7:0]       r_cnt;
    logic [11:0]      r_setp;

    scoc_pkg::t_phase n_phase;
    logic [2:0]       n_target;
    logic             n_pending;
    logic [5:0]       n_latch;
    logic             n_en;
    logic [7:0]       n_cnt;
    logic [11:0]      n_setp;
    logic [7:0]       w_tx;

    logic [7:0]  w_b;
    logic [11:0] w_b12;
    logic [7:0]  w_latch_ext;
    logic [5:0]  w_mask;
    logic [7:0]  w_cnt_inc;
    logic [11:0] w_temp;

    assign w_b         = i_req.rx_byte;
    assign w_b12       = {4'b0, w_b};
    assign w_latch_ext = {2'b0, r_latch};
    assign w_mask      = 6'b1 << r_target;
    assign w_cnt_inc   = r_cnt + 8'd1;
    assign w_temp      = {4'b0, i_req.adc_sample[9:2]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dummy <= scoc_pkg::DUMMY_BYTE_RST;
            r_tps   <= scoc_pkg::TICKS_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.idx)
                scoc_pkg::CFG_DUMMY_BYTE: r_dummy <= i_cfg.wdata;
                scoc_pkg::CFG_TICKS:      r_tps   <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

    // next parser phase
    always_comb begin
        n_phase = r_phase;
        if (i_req.op == scoc_pkg::OP_SPI) begin
            n_phase = scoc_pkg::PH_IDLE;
            unique case (r_phase)
                scoc_pkg::PH_IDLE: begin
                    if (w_b == scoc_pkg::CH_M)      n_phase = scoc_pkg::PH_ROOM;
                    else if (w_b == scoc_pkg::CH_T) n_phase = scoc_pkg::PH_SIGNAL;
                    else if (w_b == scoc_pkg::CH_A) n_phase = scoc_pkg::PH_ASUB;
                end
                scoc_pkg::PH_ROOM: begin
                    if (w_b >= scoc_pkg::CH_1 && w_b <= scoc_pkg::CH_4)
                        n_phase = scoc_pkg::PH_SIGNAL;
                end
                scoc_pkg::PH_SIGNAL: begin
                    if (w_b == scoc_pkg::CH_R)      n_phase = scoc_pkg::PH_STATUS;
                    else if (w_b == scoc_pkg::CH_W) n_phase = scoc_pkg::PH_ORDER;
                end
                scoc_pkg::PH_ASUB: begin
                    if (w_b == scoc_pkg::CH_S)      n_phase = scoc_pkg::PH_TENS;
                    else if (w_b == scoc_pkg::CH_C) n_phase = scoc_pkg::PH_SIGNAL;
                end
                scoc_pkg::PH_TENS:   n_phase = scoc_pkg::PH_UNITS;
                scoc_pkg::PH_ORDER,
                scoc_pkg::PH_UNITS,
                scoc_pkg::PH_STATUS: n_phase = scoc_pkg::PH_IDLE;
                default:             n_phase = scoc_pkg::PH_IDLE;
            endcase
        end
    end

    // data updates and reply byte
    always_comb begin
        n_target  = r_target;
        n_pending = r_pending;
        n_latch   = r_latch;
        n_en      = r_en;
        n_cnt     = r_cnt;
        n_setp    = r_setp;
        w_tx      = r_dummy;
        if (i_req.op == scoc_pkg::OP_TICK) begin
            w_tx = 8'd0;
            if (r_en) begin
                if (w_cnt_inc == r_tps) begin
                    n_cnt = 8'd0;
                    if (w_temp > r_setp)      n_latch[scoc_pkg::AC_BIT] = 1'b1;
                    else if (w_temp < r_setp) n_latch[scoc_pkg::AC_BIT] = 1'b0;
                end else begin
                    n_cnt = w_cnt_inc;
                end
            end
        end else begin
            unique case (r_phase)
                scoc_pkg::PH_IDLE: begin
                    if (w_b == scoc_pkg::CH_T) n_target = scoc_pkg::DEVICE_BIT;
                end
                scoc_pkg::PH_ROOM: begin
                    if (w_b >= scoc_pkg::CH_1 && w_b <= scoc_pkg::CH_4)
                        n_target = w_b[2:0] - scoc_pkg::CH_1[2:0];
                end
                scoc_pkg::PH_SIGNAL: begin
                    if (w_b == scoc_pkg::CH_R) n_pending = w_latch_ext[r_target];
                end
                scoc_pkg::PH_ORDER: begin
                    if (r_target == scoc_pkg::AC_BIT) begin
                        if (w_b == scoc_pkg::CH_1) begin
                            n_en = 1'b1;
                        end else if (w_b == scoc_pkg::CH_2) begin
                            n_en    = 1'b0;
                            n_latch = r_latch & ~w_mask;
                        end
                    end else if (r_target < scoc_pkg::AC_BIT) begin
                        if (w_b == scoc_pkg::CH_1)      n_latch = r_latch | w_mask;
                        else if (w_b == scoc_pkg::CH_2) n_latch = r_latch & ~w_mask;
                    end
                end
                scoc_pkg::PH_ASUB: begin
                    if (w_b == scoc_pkg::CH_C) n_target = scoc_pkg::AC_BIT;
                end
                scoc_pkg::PH_TENS:   n_setp = (w_b12 << 3) + (w_b12 << 1);
                scoc_pkg::PH_UNITS:  n_setp = r_setp + w_b12;
                scoc_pkg::PH_STATUS: w_tx   = {7'b0, r_pending};
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= scoc_pkg::PH_IDLE;
            r_target  <= 3'd0;
            r_pending <= 1'b0;
            r_latch   <= 6'd0;
            r_en      <= 1'b0;
            r_cnt     <= 8'd0;
            r_setp    <= scoc_pkg::INITIAL_SETPOINT;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_target  <= n_target;
            r_pending <= n_pending;
            r_latch   <= n_latch;
            r_en      <= n_en;
            r_cnt     <= n_cnt;
            r_setp    <= n_setp;
        end
    end

    assign o_res.tx_byte         = w_tx;
    assign o_res.output_bits     = n_latch;
    assign o_res.setpoint_value  = n_setp;
    assign o_res.cooling_enabled = n_en;

    assign o_stat.phase       = r_phase;
    assign o_stat.latch       = r_latch;
    assign o_stat.tick_enable = r_en;
    assign o_stat.setpoint    = r_setp;

endmodule

// ===== rtl/spi_command_output_controller_top.sv =====
// SPI command parser and output controller.
// Request channel (i_in_valid / o_in_ready, i_in_req): one SPI byte exchange
// (op 0, rx_byte) or one timer tick (op 1, adc_sample). Every request gives
// exactly one result on the result channel (o_out_valid / i_out_ready,
// o_out_res): the byte to shift out, the six output bits, the setpoint and
// the cooling enable after that request.
// An accepted request moves from the input register through the core into
// the result register once that is free; o_out_valid is then high.
// Throughput: one request per cycle unless the receiver stalls; the input
// register, parser/state update and result register form a two-deep pipeline.
// When the receiver stalls, the result register holds and the input
// register takes one more request, then o_in_ready drops until the result
// is taken. Parser state advances only when a request moves into the result
// register.
// Config port (i_cfg_we, i_cfg_idx, i_cfg_wdata): index 0 dummy byte,
// index 1 ticks per sample; write only while no request is in flight.
// Reset (i_rst_n low, synchronous): both pipeline stages empty, parser idle,
// all outputs off, ticks disabled, counter 0, setpoint 25, dummy byte 0,
// ticks per sample 10.
module spi_command_output_controller_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  scoc_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output scoc_pkg::t_out_req o_out_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_wdata
);

    logic                 r_in_valid;
    scoc_pkg::t_in_req    r_in;
    logic                 r_out_valid;
    scoc_pkg::t_out_req   r_out;

    logic                 w_out_free;
    logic                 w_fire;
    scoc_pkg::t_cfg_wr    w_cfg;
    scoc_pkg::t_out_req   w_res;
    scoc_pkg::t_core_stat w_stat;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_fire     = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.idx   = i_cfg_idx;
    assign w_cfg.wdata = i_cfg_wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    scoc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res),
        .o_stat  (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(w_stat))
        else $error("core state changed without a request");

    a_tick_keeps_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.op == scoc_pkg::OP_TICK) |=> $stable(w_stat.phase))
        else $error("timer tick disturbed the parser");

    a_blocked_req_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> r_in_valid)
        else $error("blocked request dropped");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out_valid && r_out.output_bits == w_stat.latch
                    && r_out.setpoint_value == w_stat.setpoint))
        else $error("result does not match updated state");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    scoc_pkg::t_in_req  in_req    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    scoc_pkg::t_out_req out_res;
    logic               cfg_we    = 1'b0;
    logic               cfg_idx   = scoc_pkg::CFG_DUMMY_BYTE;
    logic [7:0]         cfg_wdata = 8'd0;

    spi_command_output_controller_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the controller
    logic [7:0]       cfg_dummy    = scoc_pkg::DUMMY_BYTE_RST;
    logic [7:0]       cfg_tps      = scoc_pkg::TICKS_RST;
    scoc_pkg::t_phase sh_phase     = scoc_pkg::PH_IDLE;
    logic [2:0]       sh_target    = 3'd0;
    logic             sh_status    = 1'b0;
    logic [5:0]       sh_lights    = 6'd0;
    logic             sh_cool_en   = 1'b0;
    logic [7:0]       sh_tick_cnt  = 8'd0;
    logic [11:0]      sh_setpoint  = scoc_pkg::INITIAL_SETPOINT;

    scoc_pkg::t_in_req  cmd_q[$];
    scoc_pkg::t_out_req pending_outputs[$];

    int n_queued    = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_errors    = 0;
    int n_ticks     = 0;
    int n_compares  = 0;
    int n_status    = 0;
    int n_settings  = 0;
    int gen_setpoint = 25;
    int gap_left    = 0;
    int stall_left  = 0;
    int idle_cycles = 0;
    bit in_burst    = 1'b0;
    bit out_burst   = 1'b0;

    function automatic scoc_pkg::t_out_req predict_outputs(scoc_pkg::t_in_req r);
        scoc_pkg::t_out_req o;
        scoc_pkg::t_phase   nxt;
        logic [7:0] b;
        logic [7:0] room;
        logic [7:0] temp;
        o    = '0;
        b    = r.rx_byte;
        room = b - scoc_pkg::CH_1;
        if (r.op == scoc_pkg::OP_SPI) begin
            o.tx_byte = cfg_dummy;
            nxt = scoc_pkg::PH_IDLE;
            case (sh_phase)
                scoc_pkg::PH_IDLE: begin
                    if (b == scoc_pkg::CH_M) begin
                        nxt = scoc_pkg::PH_ROOM;
                    end else if (b == scoc_pkg::CH_T) begin
                        sh_target = scoc_pkg::DEVICE_BIT;
                        nxt = scoc_pkg::PH_SIGNAL;
                    end else if (b == scoc_pkg::CH_A) begin
                        nxt = scoc_pkg::PH_ASUB;
                    end
                end
                scoc_pkg::PH_ROOM: begin
                    if (b >= scoc_pkg::CH_1 && b <= scoc_pkg::CH_4) begin
                        sh_target = room[2:0];
                        nxt = scoc_pkg::PH_SIGNAL;
                    end
                end
                scoc_pkg::PH_SIGNAL: begin
                    if (b == scoc_pkg::CH_R) begin
                        sh_status = sh_lights[sh_target];
                        nxt = scoc_pkg::PH_STATUS;
                    end else if (b == scoc_pkg::CH_W) begin
                        nxt = scoc_pkg::PH_ORDER;
                    end
                end
                scoc_pkg::PH_ORDER: begin
                    if (sh_target == scoc_pkg::AC_BIT) begin
                        if (b == scoc_pkg::CH_1) begin
                            sh_cool_en = 1'b1;
                        end else if (b == scoc_pkg::CH_2) begin
                            sh_cool_en = 1'b0;
                            sh_lights[scoc_pkg::AC_BIT] = 1'b0;
                        end
                    end else if (sh_target < 3'd5) begin
                        if (b == scoc_pkg::CH_1) sh_lights[sh_target] = 1'b1;
                        else if (b == scoc_pkg::CH_2) sh_lights[sh_target] = 1'b0;
                    end
                end
                scoc_pkg::PH_ASUB: begin
                    if (b == scoc_pkg::CH_S) begin
                        nxt = scoc_pkg::PH_TENS;
                    end else if (b == scoc_pkg::CH_C) begin
                        sh_target = scoc_pkg::AC_BIT;
                        nxt = scoc_pkg::PH_SIGNAL;
                    end
                end
                scoc_pkg::PH_TENS: begin
                    sh_setpoint = {4'd0, b} * 12'd10;
                    nxt = scoc_pkg::PH_UNITS;
                end
                scoc_pkg::PH_UNITS: sh_setpoint = sh_setpoint + {4'd0, b};
                scoc_pkg::PH_STATUS: begin
                    o.tx_byte = {7'd0, sh_status};
                    n_status++;
                end
                default: ;
            endcase
            sh_phase = nxt;
        end else if (sh_cool_en) begin
            n_ticks++;
            sh_tick_cnt = sh_tick_cnt + 8'd1;
            if (sh_tick_cnt == cfg_tps) begin
                n_compares++;
                sh_tick_cnt = 8'd0;
                temp = r.adc_sample[9:2];
                if ({4'd0, temp} > sh_setpoint) sh_lights[scoc_pkg::AC_BIT] = 1'b1;
                else if ({4'd0, temp} < sh_setpoint) sh_lights[scoc_pkg::AC_BIT] = 1'b0;
            end
        end
        o.output_bits     = sh_lights;
        o.setpoint_value  = sh_setpoint;
        o.cooling_enabled = sh_cool_en;
        return o;
    endfunction

    // request side
    always @(posedge clk) begin : request_drive
        scoc_pkg::t_out_req want;
        int                 wait_cycles;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && in_ready) begin
                want = predict_outputs(in_req);
                pending_outputs.push_back(want);
                n_accepted++;
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    in_req   <= cmd_q.pop_front();
                    in_valid <= 1'b1;
                    wait_cycles = in_burst ? 0 : $urandom_range(0, 8);
                    if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
                    gap_left <= wait_cycles;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge clk) begin : result_check
        scoc_pkg::t_out_req want;
        int                 wait_cycles;
        if (!rst_n) begin
            out_ready  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && out_ready) begin
                n_results++;
                if (pending_outputs.size() == 0) begin
                    n_errors++;
                    $display("%0t result with no request outstanding: %h", $time, out_res);
                end else begin
                    want = pending_outputs.pop_front();
                    if (want.tx_byte !== out_res.tx_byte) begin
                        n_errors++;
                        $display("%0t tx_byte: expected %0h actual %0h",
                                 $time, want.tx_byte, out_res.tx_byte);
                    end
                    if (want.output_bits !== out_res.output_bits) begin
                        n_errors++;
                        $display("%0t output_bits: expected %b actual %b",
                                 $time, want.output_bits, out_res.output_bits);
                    end
                    if (want.setpoint_value !== out_res.setpoint_value) begin
                        n_errors++;
                        $display("%0t setpoint_value: expected %0d actual %0d",
                                 $time, want.setpoint_value, out_res.setpoint_value);
                    end
                    if (want.cooling_enabled !== out_res.cooling_enabled) begin
                        n_errors++;
                        $display("%0t cooling_enabled: expected %b actual %b",
                                 $time, want.cooling_enabled, out_res.cooling_enabled);
                    end
                end
                wait_cycles = out_burst ? 0 : $urandom_range(0, 8);
                if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
                stall_left <= wait_cycles;
                out_ready  <= (wait_cycles == 0);
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready  <= (stall_left == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic push_request(logic op, logic [7:0] b, logic [9:0] adc);
        scoc_pkg::t_in_req r;
        r.op         = op;
        r.rx_byte    = b;
        r.adc_sample = adc;
        cmd_q.push_back(r);
        n_queued++;
    endtask

    task automatic push_byte(logic [7:0] b);
        logic [9:0] junk;
        junk = 10'($urandom);
        push_request(scoc_pkg::OP_SPI, b, junk);
    endtask

    // one well-formed command, a broken one, noise, or a tick
    task automatic push_random_command(int tick_pct);
        logic [7:0] seq[$];
        logic [7:0] rnd;
        logic [7:0] tens;
        logic [7:0] units;
        logic [9:0] adc;
        int         k;
        int         sel;
        int         cut;
        rnd = 8'($urandom);
        if ($urandom_range(0, 99) < tick_pct) begin
            k = $urandom_range(0, 9);
            if (k < 4 && gen_setpoint < 256) adc = 10'(gen_setpoint * 4 + $urandom_range(0, 3));
            else if (k == 4) adc = 10'h3FF;
            else if (k == 5) adc = 10'h000;
            else adc = 10'($urandom_range(0, 1023));
            push_request(scoc_pkg::OP_TICK, rnd, adc);
            return;
        end
        sel = $urandom_range(0, 9);
        if (sel <= 3) begin
            seq.push_back(scoc_pkg::CH_M);
            if ($urandom_range(0, 9) == 0) seq.push_back(rnd);
            else seq.push_back(8'(scoc_pkg::CH_1 + $urandom_range(0, 3)));
        end else if (sel <= 5) begin
            seq.push_back(scoc_pkg::CH_T);
        end else if (sel <= 7) begin
            seq.push_back(scoc_pkg::CH_A);
            seq.push_back(scoc_pkg::CH_C);
        end else if (sel == 8) begin
            tens  = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 25));
            units = 8'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 9));
            seq.push_back(scoc_pkg::CH_A);
            seq.push_back(scoc_pkg::CH_S);
            seq.push_back(tens);
            seq.push_back(units);
        end else begin
            seq.push_back(rnd);
        end
        if (sel <= 7) begin
            if ($urandom_range(0, 2) == 0) begin
                seq.push_back(scoc_pkg::CH_R);
                seq.push_back(8'($urandom));
            end else begin
                seq.push_back(scoc_pkg::CH_W);
                k = $urandom_range(0, 19);
                if (k < 11) seq.push_back(scoc_pkg::CH_1);
                else if (k < 18) seq.push_back(scoc_pkg::CH_2);
                else seq.push_back(8'($urandom));
            end
        end
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, seq.size() - 1) : seq.size();
        for (int i = 0; i < seq.size(); i++) begin
            if (i == cut) begin
                push_byte(8'($urandom));
                break;
            end
            push_byte(seq[i]);
        end
        if (sel == 8 && cut == seq.size()) gen_setpoint = tens * 10 + units;
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || pending_outputs.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        if (idx == scoc_pkg::CFG_DUMMY_BYTE) cfg_dummy = val;
        else cfg_tps = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] dummy_val;
        logic [7:0] tps_val;
        int         n_items;
        int         tick_pct;
        int         n_target;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: tick while disabled, room on, status reads, bad room,
        // unknown order, setpoint maximum, cooling enable, adc extremes
        push_request(scoc_pkg::OP_TICK, 8'hFF, 10'h3FF);
        push_byte(scoc_pkg::CH_M); push_byte(scoc_pkg::CH_1);
        push_byte(scoc_pkg::CH_W); push_byte(scoc_pkg::CH_1);
        push_byte(scoc_pkg::CH_M); push_byte(scoc_pkg::CH_4);
        push_byte(scoc_pkg::CH_R); push_byte(8'hFF);
        push_byte(scoc_pkg::CH_M); push_byte(scoc_pkg::CH_1);
        push_byte(scoc_pkg::CH_R); push_byte(8'h00);
        push_byte(scoc_pkg::CH_M); push_byte(8'h35);
        push_byte(scoc_pkg::CH_T); push_byte(scoc_pkg::CH_W); push_byte(8'h37);
        push_byte(scoc_pkg::CH_A); push_byte(scoc_pkg::CH_S);
        push_byte(8'hFF); push_byte(8'hFF);
        gen_setpoint = 2805;
        push_byte(scoc_pkg::CH_A); push_byte(scoc_pkg::CH_C);
        push_byte(scoc_pkg::CH_W); push_byte(scoc_pkg::CH_1);
        push_request(scoc_pkg::OP_TICK, 8'h00, 10'h000);

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin dummy_val = 8'hFF; tps_val = 8'd1;   n_items = 300; tick_pct = 40; end
                1: begin dummy_val = 8'h00; tps_val = 8'd255; n_items = 450; tick_pct = 80; end
                2: begin dummy_val = 8'hA5; tps_val = 8'd0;   n_items = 450; tick_pct = 80; end
                3: begin
                    dummy_val = 8'($urandom);
                    tps_val   = 8'($urandom_range(2, 20));
                    n_items   = 250;
                    tick_pct  = 40;
                end
                4: begin
                    dummy_val = 8'($urandom);
                    tps_val   = 8'($urandom_range(1, 8));
                    n_items   = 250;
                    tick_pct  = 50;
                end
                default: begin dummy_val = 8'h5A; tps_val = 8'd3; n_items = 250; tick_pct = 30; end
            endcase
            wait_idle();
            write_cfg(scoc_pkg::CFG_DUMMY_BYTE, dummy_val);
            write_cfg(scoc_pkg::CFG_TICKS, tps_val);
            n_settings++;
            @(negedge clk);
            n_target = n_queued + n_items;
            push_byte(scoc_pkg::CH_A); push_byte(scoc_pkg::CH_C);
            push_byte(scoc_pkg::CH_W); push_byte(scoc_pkg::CH_1);
            while (n_queued < n_target) push_random_command(tick_pct);
        end

        wait_idle();
        $display("covered %0d requests over %0d register settings: %0d enabled ticks,",
                 n_accepted, n_settings + 1, n_ticks);
        $display("%0d temperature compares, %0d status reads, %0d results checked",
                 n_compares, n_status, n_results);
        if (n_errors == 0 && pending_outputs.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== spi_command_output_controller_top.f =====
rtl/scoc_pkg.sv
rtl/scoc_core.sv
rtl/spi_command_output_controller_top.sv
verif/tb_top.sv
